[rtl/core/read_end_trim_table_top_macros.svh]
// Assertion macros shared by the checker of the trim table block.
`ifndef READ_END_TRIM_TABLE_TOP_MACROS_SVH
`define READ_END_TRIM_TABLE_TOP_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define RETE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define RETE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rete_pkg.sv]
`default_nettype none

package rete_pkg;

    localparam int FIELD_BITS    = 20;
    localparam int READ_BITS     = 16;
    localparam int IDENT_BITS    = 17;
    localparam int FRAC_BITS     = 16;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef logic [FIELD_BITS-1:0] t_pos;
    typedef logic [READ_BITS-1:0]  t_read_idx;
    typedef logic [IDENT_BITS-1:0] t_ident;

    typedef struct packed {
        t_pos      aligned_matches;
        t_pos      other_bases;
        t_pos      query_gap_bases;
        t_pos      target_gap_bases;
        t_read_idx query_read;
        t_pos      query_length;
        t_pos      query_begin;
        t_pos      query_finish;
        t_read_idx target_read;
        t_pos      target_length;
        t_pos      target_begin;
        t_pos      target_finish;
    } t_rec;

    typedef struct packed {
        logic query_updated;
        t_pos query_left;
        t_pos query_right;
        logic query_long_enough;
        logic target_updated;
        t_pos target_left;
        t_pos target_right;
        logic target_long_enough;
    } t_res;

    typedef struct packed {
        t_ident identity_q16;
        t_pos   end_slack;
        t_pos   min_match;
        t_pos   middle_offset;
        t_pos   min_trimmed_length;
    } t_cfg;

    localparam logic [2:0] REG_IDENTITY      = 3'd0;
    localparam logic [2:0] REG_END_OFFSET    = 3'd1;
    localparam logic [2:0] REG_MIN_MATCH     = 3'd2;
    localparam logic [2:0] REG_MIDDLE_OFFSET = 3'd3;
    localparam logic [2:0] REG_MIN_TRIMMED   = 3'd4;

    localparam t_ident IDENTITY_RESET      = 17'd64225;
    localparam t_pos   END_OFFSET_RESET    = 20'd2;
    localparam t_pos   MIN_MATCH_RESET     = 20'd50;
    localparam t_pos   MIDDLE_OFFSET_RESET = 20'd50;
    localparam t_pos   MIN_TRIMMED_RESET   = 20'd2000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_QUERY,
        S_TARGET,
        S_OUT
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

[rtl/core/rete_stream_if.sv]
`default_nettype none

interface rete_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/read_end_trim_table_top.sv]
// Read end trim table.
// Alignment records arrive on i_rec (valid/ready); each accepted record gives
// exactly one result on o_res (valid/ready), carrying the left and right trim
// bounds of the query and target reads after the record, whether each entry
// was changed, and whether each kept span reaches the minimum length less two.
// The thresholds sit in five registers behind the APB port, at byte addresses
// 0, 4, 8, 12 and 16; the user must change them only while the block is idle,
// as the block itself does not enforce this. One record is worked on at a time,
// in these steps: the transfer cycle, which forms the index quotient; the index
// remainder with one read of both table entries; the query entry and then the
// target entry written back in separate cycles through the table's single
// write port; and the load of the output register.
// The result sits in an output register, so the next record is taken and
// worked on while an earlier result waits; a stalled receiver holds the
// block only once that next result is ready to be loaded.
// After reset the table is swept to zero, one entry per cycle; i_rec.ready
// stays low until the sweep is done, while register writes are taken as usual.
`default_nettype none

module read_end_trim_table_top
    import rete_pkg::*;
#(
    parameter int READ_COUNT    = 65536,
    parameter int POSITION_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rete_stream_if.sink              i_rec,
    rete_stream_if.source            o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int AW         = $clog2(READ_COUNT);
    localparam int PB         = POSITION_BITS;
    localparam int EW         = 2 * POSITION_BITS;
    localparam int VW         = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
    localparam int CW         = VW + 2;
    localparam int SUM_BITS   = FIELD_BITS + 2;
    localparam int PROD_BITS  = SUM_BITS + IDENT_BITS;
    localparam int MULT_BITS  = READ_BITS + 2;
    localparam int QPROD_BITS = READ_BITS + MULT_BITS;
    localparam bit IDX_WRAP   = (READ_COUNT <= (1 << READ_BITS));
    localparam int IDX_SHIFT  = IDX_WRAP ? (READ_BITS + AW) : 0;
    // Reciprocal of READ_COUNT, rounded up, so that the quotient is exact
    // for every sixteen-bit read index.
    localparam longint unsigned IDX_MULT =
        IDX_WRAP ? (((64'd1 << IDX_SHIFT) + READ_COUNT - 1) / READ_COUNT) : 64'd0;

    t_cfg cfg;

    t_state           r_state;
    t_state           n_state;
    logic             rec_ready;
    logic             out_load;
    t_mem_ctl         mem_ctl;
    logic             mem_busy;

    t_rec             r_rec;
    t_read_idx        r_qquot;
    t_read_idx        r_tquot;
    logic [AW-1:0]    r_qidx;
    logic [AW-1:0]    r_tidx;
    logic             r_same;
    logic [PROD_BITS-1:0] r_prod_q;
    logic [PROD_BITS-1:0] r_prod_t;
    logic             r_qcand;
    logic             r_tcand;
    logic             r_qbeg_end;
    logic             r_qstop_end;
    logic             r_tbeg_end;
    logic             r_tstop_end;
    logic             r_qupd;
    logic             r_tupd;
    logic [EW-1:0]    r_qent;
    logic [EW-1:0]    r_qfin;
    logic [EW-1:0]    r_tfin;
    t_res             r_out;
    logic             r_out_valid;

    logic [QPROD_BITS-1:0] qprod_q;
    logic [QPROD_BITS-1:0] qprod_t;
    logic [31:0]      rem_q;
    logic [31:0]      rem_t;
    logic [AW-1:0]    n_qidx;
    logic [AW-1:0]    n_tidx;
    logic [SUM_BITS-1:0] span;
    logic [PROD_BITS-1:0] n_prod_q;
    logic [PROD_BITS-1:0] n_prod_t;
    logic [PROD_BITS-1:0] lhs;
    logic signed [FIELD_BITS:0] qstop;
    logic signed [FIELD_BITS:0] tstop;
    logic signed [FIELD_BITS:0] eo_s;
    logic signed [FIELD_BITS:0] mo_s;
    logic             q_end;
    logic             t_end;
    logic             q_mid;
    logic             t_mid;
    logic             usable;
    logic             pass;
    logic             qupd_now;
    logic             tupd_now;
    logic [EW-1:0]    rd_q;
    logic [EW-1:0]    rd_t;
    logic [EW-1:0]    qnew;
    logic [EW-1:0]    tsrc;
    logic [EW-1:0]    tnew;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    t_res             n_out;

    function automatic logic [EW-1:0] trim_entry(
        input logic [EW-1:0] ent,
        input t_pos          len,
        input t_pos          beg,
        input t_pos          fin,
        input logic          beg_end,
        input logic          stop_end
    );
        logic [VW-1:0] lb;
        logic [VW-1:0] rb;
        lb = VW'(ent[EW-1:PB]);
        rb = VW'(ent[PB-1:0]);
        // An untouched read starts out spanning its whole length.
        if (lb == '0) begin
            lb = VW'(1);
            rb = (len != '0) ? VW'(len - FIELD_BITS'(1)) : '0;
        end
        if (beg_end && (lb < VW'(fin))) begin
            lb = VW'(fin);
        end
        if (stop_end && (rb > VW'(beg))) begin
            rb = VW'(beg);
        end
        return {PB'(lb), PB'(rb)};
    endfunction

    function automatic logic long_enough(input logic [EW-1:0] ent, input t_pos min_len);
        logic signed [CW-1:0] kept;
        logic signed [CW-1:0] thr;
        kept = $signed(CW'(ent[PB-1:0])) - $signed(CW'(ent[EW-1:PB]));
        thr  = $signed(CW'(min_len)) - $signed(CW'(2));
        return (ent[EW-1:PB] != '0) && (kept >= thr);
    endfunction

    rete_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rete_table_mem #(
        .DEPTH (READ_COUNT),
        .WIDTH (EW)
    ) u_table_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_raddr_a (n_qidx),
        .i_raddr_b (n_tidx),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .o_rdata_a (rd_q),
        .o_rdata_b (rd_t),
        .o_busy    (mem_busy)
    );

    assign i_rec.ready = rec_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Read index modulo READ_COUNT: the quotient comes from a multiply by the
    // reciprocal at the input transfer, the remainder in the cycle after it.
    assign qprod_q = QPROD_BITS'(i_rec.data.query_read) * QPROD_BITS'(IDX_MULT);
    assign qprod_t = QPROD_BITS'(i_rec.data.target_read) * QPROD_BITS'(IDX_MULT);
    assign rem_q   = 32'(r_rec.query_read) - 32'(r_qquot) * 32'(READ_COUNT);
    assign rem_t   = 32'(r_rec.target_read) - 32'(r_tquot) * 32'(READ_COUNT);
    assign n_qidx  = IDX_WRAP ? AW'(rem_q) : AW'(r_rec.query_read);
    assign n_tidx  = IDX_WRAP ? AW'(rem_t) : AW'(r_rec.target_read);

    // Identity test terms.
    assign span     = SUM_BITS'(r_rec.aligned_matches) + SUM_BITS'(r_rec.other_bases);
    assign n_prod_q = PROD_BITS'(span + SUM_BITS'(r_rec.query_gap_bases))
                      * PROD_BITS'(cfg.identity_q16);
    assign n_prod_t = PROD_BITS'(span + SUM_BITS'(r_rec.target_gap_bases))
                      * PROD_BITS'(cfg.identity_q16);
    assign lhs      = PROD_BITS'(r_rec.aligned_matches) << FRAC_BITS;
    assign pass     = (lhs >= r_prod_q) && (lhs >= r_prod_t);

    // Distances to the far ends may be negative and then count as at the end.
    assign qstop  = $signed({1'b0, r_rec.query_length}) - $signed({1'b0, r_rec.query_finish});
    assign tstop  = $signed({1'b0, r_rec.target_length})
                    - $signed({1'b0, r_rec.target_finish});
    assign eo_s   = $signed({1'b0, cfg.end_slack});
    assign mo_s   = $signed({1'b0, cfg.middle_offset});
    assign q_end  = (r_rec.query_begin <= cfg.end_slack) || (qstop <= eo_s);
    assign t_end  = (r_rec.target_begin <= cfg.end_slack) || (tstop <= eo_s);
    assign q_mid  = (r_rec.query_begin >= cfg.middle_offset) && (qstop >= mo_s);
    assign t_mid  = (r_rec.target_begin >= cfg.middle_offset) && (tstop >= mo_s);
    assign usable = (r_rec.query_read != r_rec.target_read)
                    && (r_rec.aligned_matches >= cfg.min_match);

    assign qupd_now = r_qcand && pass;
    assign tupd_now = r_tcand && pass;

    assign qnew = qupd_now
                  ? trim_entry(rd_q, r_rec.query_length, r_rec.query_begin,
                               r_rec.query_finish, r_qbeg_end, r_qstop_end)
                  : rd_q;
    // When both indices land on one entry the target sees the query's update.
    assign tsrc = r_same ? r_qent : rd_t;
    assign tnew = r_tupd
                  ? trim_entry(tsrc, r_rec.target_length, r_rec.target_begin,
                               r_rec.target_finish, r_tbeg_end, r_tstop_end)
                  : tsrc;

    assign wr_addr = (r_state == S_QUERY) ? r_qidx : r_tidx;
    assign wr_data = (r_state == S_QUERY) ? qnew : tnew;

    always_comb begin
        n_out.query_updated      = r_qupd;
        n_out.query_left         = FIELD_BITS'(r_qfin[EW-1:PB]);
        n_out.query_right        = FIELD_BITS'(r_qfin[PB-1:0]);
        n_out.query_long_enough  = long_enough(r_qfin, cfg.min_trimmed_length);
        n_out.target_updated     = r_tupd;
        n_out.target_left        = FIELD_BITS'(r_tfin[EW-1:PB]);
        n_out.target_right       = FIELD_BITS'(r_tfin[PB-1:0]);
        n_out.target_long_enough = long_enough(r_tfin, cfg.min_trimmed_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        rec_ready     = 1'b0;
        out_load      = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rec_ready = !mem_busy;
                if (i_rec.valid && !mem_busy) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                mem_ctl.rd_en = 1'b1;
                n_state       = S_QUERY;
            end
            S_QUERY: begin
                mem_ctl.wr_en = qupd_now;
                n_state       = S_TARGET;
            end
            S_TARGET: begin
                mem_ctl.wr_en = r_tupd;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rec_ready && i_rec.valid) begin
            r_rec   <= i_rec.data;
            r_qquot <= READ_BITS'(qprod_q >> IDX_SHIFT);
            r_tquot <= READ_BITS'(qprod_t >> IDX_SHIFT);
        end
        if (r_state == S_ADDR) begin
            r_qidx      <= n_qidx;
            r_tidx      <= n_tidx;
            r_same      <= (n_qidx == n_tidx);
            r_prod_q    <= n_prod_q;
            r_prod_t    <= n_prod_t;
            r_qcand     <= usable && q_end && t_mid;
            r_tcand     <= usable && t_end && q_mid;
            r_qbeg_end  <= (r_rec.query_begin <= cfg.end_slack);
            r_qstop_end <= (qstop <= eo_s);
            r_tbeg_end  <= (r_rec.target_begin <= cfg.end_slack);
            r_tstop_end <= (tstop <= eo_s);
        end
        if (r_state == S_QUERY) begin
            r_qent <= qnew;
            r_qupd <= qupd_now;
            r_tupd <= tupd_now;
        end
        if (r_state == S_TARGET) begin
            r_qfin <= r_same ? tnew : r_qent;
            r_tfin <= tnew;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rete_cfg_regs.sv]
`default_nettype none

module rete_cfg_regs
    import rete_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.identity_q16       <= IDENTITY_RESET;
            r_cfg.end_slack          <= END_OFFSET_RESET;
            r_cfg.min_match          <= MIN_MATCH_RESET;
            r_cfg.middle_offset      <= MIDDLE_OFFSET_RESET;
            r_cfg.min_trimmed_length <= MIN_TRIMMED_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_IDENTITY:      r_cfg.identity_q16       <= IDENT_BITS'(pwdata);
                REG_END_OFFSET:    r_cfg.end_slack          <= FIELD_BITS'(pwdata);
                REG_MIN_MATCH:     r_cfg.min_match          <= FIELD_BITS'(pwdata);
                REG_MIDDLE_OFFSET: r_cfg.middle_offset      <= FIELD_BITS'(pwdata);
                REG_MIN_TRIMMED:   r_cfg.min_trimmed_length <= FIELD_BITS'(pwdata);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_IDENTITY:      prdata = APB_DATA_BITS'(r_cfg.identity_q16);
            REG_END_OFFSET:    prdata = APB_DATA_BITS'(r_cfg.end_slack);
            REG_MIN_MATCH:     prdata = APB_DATA_BITS'(r_cfg.min_match);
            REG_MIDDLE_OFFSET: prdata = APB_DATA_BITS'(r_cfg.middle_offset);
            REG_MIN_TRIMMED:   prdata = APB_DATA_BITS'(r_cfg.min_trimmed_length);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/rete_table_mem.sv]
`default_nettype none

module rete_table_mem
    import rete_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_mem_ctl                          i_ctl,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr_b,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    output logic [WIDTH-1:0]                  o_rdata_a,
    output logic [WIDTH-1:0]                  o_rdata_b,
    output logic                              o_busy
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
    assign o_busy    = r_clr_busy;

    // After reset every entry is swept to zero, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

[rtl/core/rete_checker.sv]
`default_nettype none

`include "read_end_trim_table_top_macros.svh"

module rete_checker
    import rete_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_out_data
);

    logic [1:0] r_cnt;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // Records taken whose result has not yet been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (out_xfer && !in_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    `RETE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")
    `RETE_ASSERT_NEXT(a_one_record, i_clk, i_rst_n, in_xfer, !i_in_ready, "record taken while another is in work")
    `RETE_ASSERT_NOW(a_no_extra, i_clk, i_rst_n, i_out_valid || i_in_ready, (!i_out_valid || r_cnt != 2'd0) && (!i_in_ready || r_cnt == 2'd0 || r_cnt == 2'd1), "result count out of step with records")
    `RETE_ASSERT_NOW(a_untouched, i_clk, i_rst_n, i_out_valid, (i_out_data.query_left != '0 || !i_out_data.query_long_enough) && (i_out_data.target_left != '0 || !i_out_data.target_long_enough), "untouched read reported long enough")

endmodule

bind read_end_trim_table_top rete_checker u_rete_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rec.valid),
    .i_in_ready  (i_rec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire
